/* src/bmp24_pkg.sv */
// bmp24_pkg: request types, phase encoding and header constants for the bitmap decoder
// no dependencies; used by bmp24_out_skid and bmp24_stream_decoder
package bmp24_pkg;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       file_start;
    } t_in_req;

    typedef struct packed {
        logic [11:0] pixel_x;
        logic [11:0] pixel_y;
        logic [7:0]  red;
        logic [7:0]  green;
        logic [7:0]  blue;
        logic        last_pixel;
        logic        dim_error;
    } t_out_req;

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_HEADER,
        PH_PIXELS,
        PH_ERROR
    } t_phase;

    typedef enum logic [1:0] {
        COMP_BLUE,
        COMP_GREEN,
        COMP_RED
    } t_comp;

    // header layout
    localparam logic [5:0] HDR_LAST   = 6'd53;
    localparam logic [5:0] WIDTH_OFS  = 6'd18;
    localparam logic [5:0] HEIGHT_OFS = 6'd22;
    localparam logic [5:0] FIELD_END  = 6'd26;

endpackage

/* src/bmp24_stream_decoder.sv */
// bmp24_stream_decoder: streaming decoder for 24-bit bitmap files, one byte per request
// depends on bmp24_pkg and bmp24_out_skid
//
//  channel | direction | handshake                 | payload
//  --------+-----------+---------------------------+--------------------------------
//  in      | input     | i_in_valid / o_in_ready   | i_in_data  (data_byte, file_start)
//  out     | output    | o_out_valid / i_out_ready | o_out_data (pixel, color, flags)
//
// one byte request is taken per cycle while o_in_ready is high; the whole parse step is the
// single phase/counter update between the input handshake and the result register, so a result
// is registered as its red byte is accepted (or the last header byte, for a size error)
// synchronous active-low reset clears the phase and counters; there is no clearing pass
// a stalled output fills the skid stage, after which o_in_ready drops until it drains
module bmp24_stream_decoder #(
    parameter int unsigned MAX_DIM = 4096
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  bmp24_pkg::t_in_req  i_in_data,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output bmp24_pkg::t_out_req o_out_data
);
    import bmp24_pkg::*;

    // coordinate counter width and width compare width
    localparam int CW = $clog2(MAX_DIM);
    localparam int DW = $clog2(MAX_DIM + 1);
    localparam int XW = (CW > 12) ? CW : 12;

    // parse state
    t_phase      r_phase,  n_phase;
    logic [5:0]  r_hcount, n_hcount;
    logic [31:0] r_width,  n_width;
    logic [31:0] r_height, n_height;
    logic [CW-1:0] r_col,  n_col;
    logic [CW-1:0] r_row,  n_row;
    t_comp       r_comp,   n_comp;
    logic [7:0]  r_blue,   n_blue;
    logic [7:0]  r_green,  n_green;
    logic [1:0]  r_pad,    n_pad;

    // step signals
    logic        in_acc;
    logic        res_valid;
    t_out_req    res;
    logic        hdr_active;
    logic [5:0]  idx;
    logic [1:0]  lane;
    logic [DW-1:0] col_inc;
    logic        last_col;
    logic [XW-1:0] x_ext;
    logic [XW-1:0] y_ext;

    assign in_acc  = i_in_valid && o_in_ready;
    assign col_inc = DW'(r_col) + DW'(1);
    assign last_col = col_inc >= r_width[DW-1:0];
    assign x_ext   = XW'(r_col);
    assign y_ext   = XW'(r_row);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_IDLE;
            r_hcount <= '0;
            r_width  <= '0;
            r_height <= '0;
            r_col    <= '0;
            r_row    <= '0;
            r_comp   <= COMP_BLUE;
            r_blue   <= '0;
            r_green  <= '0;
            r_pad    <= '0;
        end else if (in_acc) begin
            r_phase  <= n_phase;
            r_hcount <= n_hcount;
            r_width  <= n_width;
            r_height <= n_height;
            r_col    <= n_col;
            r_row    <= n_row;
            r_comp   <= n_comp;
            r_blue   <= n_blue;
            r_green  <= n_green;
            r_pad    <= n_pad;
        end
    end

    always_comb begin
        n_phase  = r_phase;
        n_hcount = r_hcount;
        n_width  = r_width;
        n_height = r_height;
        n_col    = r_col;
        n_row    = r_row;
        n_comp   = r_comp;
        n_blue   = r_blue;
        n_green  = r_green;
        n_pad    = r_pad;
        res_valid = 1'b0;
        res       = '0;
        lane      = '0;

        // file start aborts anything and makes this byte header byte 0
        if (i_in_data.file_start) begin
            n_phase  = PH_HEADER;
            n_hcount = '0;
            n_width  = '0;
            n_height = '0;
            n_col    = '0;
            n_row    = '0;
            n_comp   = COMP_BLUE;
            n_blue   = '0;
            n_green  = '0;
            n_pad    = '0;
        end
        hdr_active = i_in_data.file_start || (r_phase == PH_HEADER);
        idx        = i_in_data.file_start ? 6'd0 : r_hcount;

        if (hdr_active) begin
            // little-endian width and height fields
            if (idx >= WIDTH_OFS && idx < HEIGHT_OFS) begin
                lane = 2'(idx - WIDTH_OFS);
                n_width[{lane, 3'b000} +: 8] = i_in_data.data_byte;
            end else if (idx >= HEIGHT_OFS && idx < FIELD_END) begin
                lane = 2'(idx - HEIGHT_OFS);
                n_height[{lane, 3'b000} +: 8] = i_in_data.data_byte;
            end
            n_hcount = idx + 6'd1;
            if (idx == HDR_LAST) begin
                if (r_width > 32'(MAX_DIM) || r_height > 32'(MAX_DIM)) begin
                    n_phase         = PH_ERROR;
                    res_valid       = 1'b1;
                    res.dim_error   = 1'b1;
                end else if (r_width == '0 || r_height == '0) begin
                    n_phase = PH_IDLE;
                end else begin
                    n_phase = PH_PIXELS;
                    n_col   = '0;
                    n_row   = CW'(r_height - 32'd1);
                    n_comp  = COMP_BLUE;
                    n_blue  = '0;
                    n_green = '0;
                    n_pad   = '0;
                end
            end
        end else if (r_phase == PH_PIXELS) begin
            if (r_pad != 2'd0) begin
                n_pad = r_pad - 2'd1;
            end else begin
                unique case (r_comp)
                    COMP_BLUE: begin
                        n_blue = i_in_data.data_byte;
                        n_comp = COMP_GREEN;
                    end
                    COMP_GREEN: begin
                        n_green = i_in_data.data_byte;
                        n_comp  = COMP_RED;
                    end
                    default: begin
                        res_valid      = 1'b1;
                        res.pixel_x    = x_ext[11:0];
                        res.pixel_y    = y_ext[11:0];
                        res.red        = i_in_data.data_byte;
                        res.green      = r_green;
                        res.blue       = r_blue;
                        res.last_pixel = last_col && (r_row == '0);
                        n_comp  = COMP_BLUE;
                        n_blue  = '0;
                        n_green = '0;
                        if (last_col) begin
                            n_col = '0;
                            if (r_row == '0) begin
                                n_phase = PH_IDLE;
                            end else begin
                                n_row = r_row - CW'(1);
                                // row padding (4 - 3w mod 4) mod 4 equals w mod 4
                                n_pad = r_width[1:0];
                            end
                        end else begin
                            n_col = r_col + CW'(1);
                        end
                    end
                endcase
            end
        end
    end

    bmp24_out_skid u_out (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (in_acc && res_valid),
        .i_push_data (res),
        .o_ready     (o_in_ready),
        .o_valid     (o_out_valid),
        .i_ready     (i_out_ready),
        .o_data      (o_out_data)
    );

    // image in progress always has a legal nonzero size
    a_pixels_size: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_PIXELS) |-> (r_width != '0 && r_width <= 32'(MAX_DIM)
                                    && r_height != '0 && r_height <= 32'(MAX_DIM)))
        else $error("pixel phase with illegal image size");

    // column stays inside the row
    a_col_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_PIXELS) |-> (DW'(r_col) < r_width[DW-1:0]))
        else $error("column beyond image width");

    // padding only pending between pixel rows
    a_pad_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_pad != 2'd0) |-> (r_phase == PH_PIXELS && r_comp == COMP_BLUE))
        else $error("padding pending outside a row boundary");

endmodule

/* src/bmp24_out_skid.sv */
// bmp24_out_skid: two-entry result register (output stage plus skid stage)
// depends on bmp24_pkg for the result request type
module bmp24_out_skid (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  bmp24_pkg::t_out_req i_push_data,
    output logic                o_ready,
    output logic                o_valid,
    input  logic                i_ready,
    output bmp24_pkg::t_out_req o_data
);
    import bmp24_pkg::*;

    logic     r_out_valid;
    logic     r_skid_valid;
    t_out_req r_out;
    t_out_req r_skid;
    logic     take;

    assign take    = !r_out_valid || i_ready;
    assign o_ready = !r_skid_valid;
    assign o_valid = r_out_valid;
    assign o_data  = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (take) begin
            if (r_skid_valid) begin
                // push cannot happen while the skid entry is full
                r_out        <= r_skid;
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end else begin
                r_out       <= i_push_data;
                r_out_valid <= i_push;
            end
        end else if (i_push) begin
            r_skid       <= i_push_data;
            r_skid_valid <= 1'b1;
        end
    end

    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid entry held with empty output stage");

    // a stalled result stays put until it is taken
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_ready) |=> (r_out_valid && $stable(r_out)))
        else $error("output request changed while stalled");

    // a push only arrives when there is room for it
    a_push_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> !r_skid_valid)
        else $error("push while both stages are full");

endmodule
